@@ hw/rtl/cmf_pkg.sv @@
// Package for the complex matched-filter correlator: widths, limits and
// the word structs passed between the pipeline stages. No dependencies.
package cmf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_WINDOW = 1024;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int PROD_W     = 2 * SAMPLE_W + 1;   // sum of two Q30 products
    localparam int ACC_W      = 48;
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 1 << 14;
    localparam int Q15_MAX    = 32767;
    localparam int Q15_MIN    = -32768;
    localparam int IN_DATA_W  = 4 * SAMPLE_W;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic signed [SAMPLE_W-1:0] replica_re;
        logic signed [SAMPLE_W-1:0] replica_im;
        logic                       window_end;
    } t_elem;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_re;
        logic signed [PROD_W-1:0] p_im;
        logic                     last;
    } t_prod;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_re;
        logic signed [ACC_W-1:0] sum_im;
        logic                    ovf;
    } t_sum;

endpackage

@@ hw/rtl/cmf_cmul.sv @@
// Complex multiply stage: four 16x16 products combined into the real and
// imaginary Q30 terms, registered. Uses cmf_pkg.
module cmf_cmul (
    input  logic           i_clk,
    input  logic           i_en,
    input  cmf_pkg::t_elem i_elem,
    output cmf_pkg::t_prod o_prod
);
    import cmf_pkg::*;

    logic signed [2*SAMPLE_W-1:0] m_rr;
    logic signed [2*SAMPLE_W-1:0] m_qq;
    logic signed [2*SAMPLE_W-1:0] m_rq;
    logic signed [2*SAMPLE_W-1:0] m_qr;
    t_prod                        r_prod;
    t_prod                        n_prod;

    assign m_rr = i_elem.sample_re * i_elem.replica_re;
    assign m_qq = i_elem.sample_im * i_elem.replica_im;
    assign m_rq = i_elem.sample_re * i_elem.replica_im;
    assign m_qr = i_elem.sample_im * i_elem.replica_re;

    always_comb begin
        n_prod.p_re = PROD_W'(m_rr) - PROD_W'(m_qq);
        n_prod.p_im = PROD_W'(m_rq) + PROD_W'(m_qr);
        n_prod.last = i_elem.window_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/cmf_accum.sv @@
// Window accumulator: exact Q30 sums, element count and overflow flag.
// Hands the finished sums over on the last word. Uses cmf_pkg.
module cmf_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  cmf_pkg::t_prod i_prod,
    output cmf_pkg::t_sum  o_sum
);
    import cmf_pkg::*;

    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic        [CNT_W-1:0] r_count;
    logic                    r_ovf;
    logic signed [ACC_W-1:0] n_acc_re;
    logic signed [ACC_W-1:0] n_acc_im;
    logic        [CNT_W-1:0] n_count;
    logic                    n_ovf;
    logic                    room;
    t_sum                    r_sum;

    assign room = (r_count < CNT_W'(MAX_WINDOW));

    // past the window limit the sums hold and only the flag is set
    always_comb begin
        if (room) begin
            n_acc_re = r_acc_re + ACC_W'(i_prod.p_re);
            n_acc_im = r_acc_im + ACC_W'(i_prod.p_im);
            n_count  = CNT_W'(r_count + 1'b1);
            n_ovf    = r_ovf;
        end else begin
            n_acc_re = r_acc_re;
            n_acc_im = r_acc_im;
            n_count  = r_count;
            n_ovf    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_take) begin
            if (i_prod.last) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_acc_re <= n_acc_re;
                r_acc_im <= n_acc_im;
                r_count  <= n_count;
                r_ovf    <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_prod.last) begin
            r_sum.sum_re <= n_acc_re;
            r_sum.sum_im <= n_acc_im;
            r_sum.ovf    <= n_ovf;
        end
    end

    assign o_sum = r_sum;

endmodule

@@ hw/rtl/cmf_round.sv @@
// Output stage: sign-dependent half bias of the Q30 sums, floor shift to Q15
// and saturation into the result register. Uses cmf_pkg.
module cmf_round (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  cmf_pkg::t_sum                     i_sum,
    output logic signed [cmf_pkg::SAMPLE_W-1:0] o_corr_re,
    output logic signed [cmf_pkg::SAMPLE_W-1:0] o_corr_im,
    output logic                              o_window_overflow
);
    import cmf_pkg::*;

    function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] q;
        logic signed [SAMPLE_W-1:0] res;
        // add half for positive, subtract half for negative, then floor shift
        if (x[ACC_W-1]) begin
            biased = x - ACC_W'(ROUND_HALF);
        end else begin
            biased = x + ACC_W'(ROUND_HALF);
        end
        q = biased >>> FRAC_SHIFT;
        if (q > ACC_W'(Q15_MAX)) begin
            res = SAMPLE_W'(Q15_MAX);
        end else if (q < ACC_W'(Q15_MIN)) begin
            res = SAMPLE_W'(Q15_MIN);
        end else begin
            res = SAMPLE_W'(q);
        end
        return res;
    endfunction

    logic signed [SAMPLE_W-1:0] r_corr_re;
    logic signed [SAMPLE_W-1:0] r_corr_im;
    logic                       r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_corr_re <= q30_to_q15(i_sum.sum_re);
            r_corr_im <= q30_to_q15(i_sum.sum_im);
            r_ovf     <= i_sum.ovf;
        end
    end

    assign o_corr_re         = r_corr_re;
    assign o_corr_im         = r_corr_im;
    assign o_window_overflow = r_ovf;

endmodule

@@ hw/rtl/complex_matched_filter_q15.sv @@
// Complex Q15 matched-filter correlator. Each input word is one window element
// (sample and pre-reversed, conjugated replica); the word with tlast closes the
// window and yields one output word with the rounded, saturated Q15 real and
// imaginary correlation and an overflow flag in tuser (set when the window ran
// past MAX_WINDOW elements; only the first MAX_WINDOW are summed). One word is
// taken per clock unless a stall holds input back; the result leaves four
// register stages after its last element (input, product, accumulator,
// rounding). A stalled output holds back input only once the rounding and
// sum stages are full and the next window's last element waits in the
// product stage; other elements keep flowing into the accumulator.
// Top level; uses cmf_pkg, cmf_cmul, cmf_accum, cmf_round.
module complex_matched_filter_q15 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_re[15:0], sample_im[31:16], replica_re[47:32], replica_im[63:48]
    input  logic [cmf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic        s_axis_tlast,   // window_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // corr_re[15:0], corr_im[31:16]
    output logic [cmf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser    // window_overflow
);
    import cmf_pkg::*;

    logic                       r1_valid;
    logic                       r2_valid;
    logic                       r3_valid;
    logic                       r4_valid;
    t_elem                      r_elem;
    t_prod                      prod;
    t_sum                       sum;
    logic                       take2;
    logic                       take3;
    logic                       take4;
    logic                       s1_free;
    logic                       s2_free;
    logic                       s3_free;
    logic                       accept;
    logic signed [SAMPLE_W-1:0] corr_re;
    logic signed [SAMPLE_W-1:0] corr_im;
    logic                       corr_ovf;

    // only last-element words reach the sum stage
    assign take4   = r3_valid && (!r4_valid || m_axis_tready);
    assign s3_free = !r3_valid || take4;
    assign take3   = r2_valid && (!prod.last || s3_free);
    assign s2_free = !r2_valid || take3;
    assign take2   = r1_valid && s2_free;
    assign s1_free = !r1_valid || take2;
    assign accept  = s_axis_tvalid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r1_valid <= s_axis_tvalid;
            end
            if (s2_free) begin
                r2_valid <= r1_valid;
            end
            if (s3_free) begin
                r3_valid <= take3 && prod.last;
            end
            if (!r4_valid || m_axis_tready) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elem.sample_re  <= s_axis_tdata[SAMPLE_W-1:0];
            r_elem.sample_im  <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            r_elem.replica_re <= s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            r_elem.replica_im <= s_axis_tdata[IN_DATA_W-1:3*SAMPLE_W];
            r_elem.window_end <= s_axis_tlast;
        end
    end

    cmf_cmul u_cmul (
        .i_clk  (i_clk),
        .i_en   (take2),
        .i_elem (r_elem),
        .o_prod (prod)
    );

    cmf_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take3),
        .i_prod  (prod),
        .o_sum   (sum)
    );

    cmf_round u_round (
        .i_clk             (i_clk),
        .i_load            (take4),
        .i_sum             (sum),
        .o_corr_re         (corr_re),
        .o_corr_im         (corr_im),
        .o_window_overflow (corr_ovf)
    );

    assign s_axis_tready = s1_free;
    assign m_axis_tvalid = r4_valid;
    assign m_axis_tdata  = {corr_im, corr_re};
    assign m_axis_tuser  = corr_ovf;

endmodule
